[rtl/apc_pkg.sv]
`default_nettype none
package apc_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POINT,
    ST_EDGE,
    ST_EMIT_A,
    ST_ISECT,
    ST_IWAIT,
    ST_EMIT_X,
    ST_EMIT_B,
    ST_EMIT_INV,
    ST_NEXT,
    ST_CLOSE
  } state_e;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_ALT_Z = 2'd3;

  localparam logic [1:0] KIND_POINT       = 2'd0;
  localparam logic [1:0] KIND_SEGMENT     = 2'd1;
  localparam logic [1:0] KIND_POLYGON     = 2'd2;
  localparam logic [1:0] KIND_ALT_POLYGON = 2'd3;

  localparam logic REG_AXIS  = 1'b0;
  localparam logic REG_PLANE = 1'b1;

endpackage
`default_nettype wire

[rtl/apc_isect.sv]
`default_nettype none
module apc_isect #(
  parameter int W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W:0]   mag_a_i,
  input  wire logic [W:0]   mag_b_i,
  input  wire logic [W:0]   div_i,
  output logic      [W:0]   quo_o,
  output logic              done_o
);

  localparam int CW = $clog2(2 * W + 2);
  localparam logic [CW-1:0] MUL_LAST = CW'(W);
  localparam logic [CW-1:0] DIV_LAST = CW'(2 * W + 1);

  logic            busy_q, phase_q, done_q;
  logic [CW-1:0]   cnt_q;
  logic [W:0]      a_q, b_q, d_q, rem_q, quo_q;
  logic [2*W+1:0]  prod_q;
  logic [W+1:0]    trial;
  logic            fits;

  // shift-add multiply, MSB first, then restoring divide on the product
  assign trial = {rem_q, prod_q[2*W+1]};
  assign fits  = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        cnt_q   <= '0;
      end else if (busy_q) begin
        if (!phase_q) begin
          if (cnt_q == MUL_LAST) begin
            phase_q <= 1'b1;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end else if (cnt_q == DIV_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      a_q    <= mag_a_i;
      b_q    <= mag_b_i;
      d_q    <= div_i;
      prod_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (busy_q) begin
      if (!phase_q) begin
        prod_q <= {prod_q[2*W:0], 1'b0} + (b_q[W] ? {{(W+1){1'b0}}, a_q} : '0);
        b_q    <= {b_q[W-1:0], 1'b0};
      end else begin
        prod_q <= {prod_q[2*W:0], 1'b0};
        rem_q  <= fits ? (trial[W:0] - d_q) : trial[W:0];
        quo_q  <= {quo_q[W-1:0], fits};
      end
    end
  end

  assign quo_o  = (d_q == '0) ? '0 : quo_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

[rtl/axis_plane_polygon_clipper_core.sv]
`default_nettype none
// Clips points, segments and polygons against one axis-aligned plane, one vertex per
// input transaction, and emits the clipped vertices one per output transaction. Each
// crossing edge sends both non-tested coordinates one after the other through a single
// bit-serial multiplier and restoring divider. Input is taken only between vertices.
// Configure clip_axis (offset 0) and clip_plane (offset 4) while idle.
module axis_plane_polygon_clipper_core #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [COORD_BITS-1:0] coord_x_i,
  input  wire logic [COORD_BITS-1:0] coord_y_i,
  input  wire logic [COORD_BITS-1:0] coord_z_i,
  input  wire logic [1:0]            prim_kind_i,
  input  wire logic                  first_vertex_i,
  input  wire logic                  last_vertex_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [COORD_BITS-1:0] out_x_o,
  output logic      [COORD_BITS-1:0] out_y_o,
  output logic      [COORD_BITS-1:0] out_z_o,
  output logic                       vertex_valid_o,
  output logic                       end_of_prim_o,
  output logic                       entered_flag_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  localparam int W = COORD_BITS;

  typedef logic [2:0][W-1:0] vert_t;

  apc_pkg::state_e state_q, state_d;

  logic [1:0]  axis_q;
  logic [31:0] plane_q;
  logic [W+31:0] plane_ext;
  logic signed [W-1:0] pl;
  logic [1:0] ax, oth0, oth1, ksel;

  vert_t v_q, start_q, prev_q, fe_q, a_q, b_q, x_q, out_v_q, em_vert;
  logic [1:0] kind_q;
  logic first_q, last_q, seg_q, pass_q, ka_q, kb_q, isel_q;
  logic any_q, ent_q;
  logic out_valid_q, out_vv_q, out_eop_q, out_ent_q;

  logic slot_free, ka, kb, kv;
  logic em_go, em_valid, em_eop, em_ent, em_rec;
  logic latch_edge, set_ent, unit_start, unit_done, store_x, prev_take;
  logic [W:0] dk, pa, da, mag_dk, mag_pa, mag_da, quo, sq, res;
  logic neg;

  function automatic logic kept_f(vert_t p, logic [1:0] a, logic signed [W-1:0] l);
    logic signed [W-1:0] c;
    c = p[a];
    if (a == apc_pkg::AXIS_Z || l <= 0) begin
      return c >= l;
    end
    return c <= l;
  endfunction

  assign plane_ext = {{W{1'b0}}, plane_q};
  assign pl   = plane_ext[W-1:0];
  assign ax   = (axis_q == apc_pkg::AXIS_ALT_Z) ? apc_pkg::AXIS_Z : axis_q;
  assign oth0 = (ax == apc_pkg::AXIS_X) ? apc_pkg::AXIS_Y : apc_pkg::AXIS_X;
  assign oth1 = (ax == apc_pkg::AXIS_Z) ? apc_pkg::AXIS_Y : apc_pkg::AXIS_Z;
  assign ksel = isel_q ? oth1 : oth0;

  assign ka = kept_f(a_q, ax, pl);
  assign kb = kept_f(b_q, ax, pl);
  assign kv = kept_f(v_q, ax, pl);

  assign dk = {b_q[ksel][W-1], b_q[ksel]} - {a_q[ksel][W-1], a_q[ksel]};
  assign pa = {b_q[ax][W-1], b_q[ax]} - {pl[W-1], pl};
  assign da = {b_q[ax][W-1], b_q[ax]} - {a_q[ax][W-1], a_q[ax]};
  assign mag_dk = dk[W] ? -dk : dk;
  assign mag_pa = pa[W] ? -pa : pa;
  assign mag_da = da[W] ? -da : da;
  assign neg = dk[W] ^ pa[W] ^ da[W];
  assign sq  = neg ? -quo : quo;
  assign res = {b_q[ksel][W-1], b_q[ksel]} - sq;

  apc_isect #(.W(W)) u_isect (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(unit_start),
    .mag_a_i(mag_dk),
    .mag_b_i(mag_pa),
    .div_i  (mag_da),
    .quo_o  (quo),
    .done_o (unit_done)
  );

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    em_go      = 1'b0;
    em_vert    = v_q;
    em_valid   = 1'b1;
    em_eop     = 1'b0;
    em_ent     = ent_q;
    em_rec     = 1'b0;
    latch_edge = 1'b0;
    set_ent    = 1'b0;
    unit_start = 1'b0;
    store_x    = 1'b0;
    prev_take  = 1'b0;
    case (state_q)
      apc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = apc_pkg::ST_DECODE;
      end
      apc_pkg::ST_DECODE: begin
        if (kind_q == apc_pkg::KIND_POINT || (first_q && last_q)) begin
          state_d = apc_pkg::ST_POINT;
        end else if (first_q) begin
          state_d = apc_pkg::ST_IDLE;
        end else begin
          latch_edge = 1'b1;
          state_d    = apc_pkg::ST_EDGE;
        end
      end
      apc_pkg::ST_POINT: begin
        em_vert  = kv ? v_q : '0;
        em_valid = kv;
        em_eop   = 1'b1;
        em_ent   = 1'b0;
        if (slot_free) begin
          em_go   = 1'b1;
          state_d = apc_pkg::ST_IDLE;
        end
      end
      apc_pkg::ST_EDGE: begin
        if (ka) begin
          state_d = apc_pkg::ST_EMIT_A;
        end else if (kb) begin
          set_ent = 1'b1;
          state_d = apc_pkg::ST_ISECT;
        end else begin
          state_d = seg_q ? apc_pkg::ST_EMIT_INV : apc_pkg::ST_NEXT;
        end
      end
      apc_pkg::ST_EMIT_A: begin
        em_vert = a_q;
        em_rec  = !seg_q;
        if (slot_free) begin
          em_go = 1'b1;
          if (kb_q) state_d = seg_q ? apc_pkg::ST_EMIT_B : apc_pkg::ST_NEXT;
          else      state_d = apc_pkg::ST_ISECT;
        end
      end
      apc_pkg::ST_ISECT: begin
        unit_start = 1'b1;
        state_d    = apc_pkg::ST_IWAIT;
      end
      apc_pkg::ST_IWAIT: begin
        if (unit_done) begin
          store_x = 1'b1;
          state_d = isel_q ? apc_pkg::ST_EMIT_X : apc_pkg::ST_ISECT;
        end
      end
      apc_pkg::ST_EMIT_X: begin
        em_vert = x_q;
        em_rec  = !seg_q;
        em_eop  = seg_q && ka_q;
        if (slot_free) begin
          em_go   = 1'b1;
          state_d = (seg_q && !ka_q) ? apc_pkg::ST_EMIT_B : apc_pkg::ST_NEXT;
        end
      end
      apc_pkg::ST_EMIT_B: begin
        em_vert = b_q;
        em_eop  = 1'b1;
        if (slot_free) begin
          em_go   = 1'b1;
          state_d = apc_pkg::ST_NEXT;
        end
      end
      apc_pkg::ST_EMIT_INV: begin
        em_vert  = '0;
        em_valid = 1'b0;
        em_eop   = 1'b1;
        if (slot_free) begin
          em_go   = 1'b1;
          state_d = apc_pkg::ST_NEXT;
        end
      end
      apc_pkg::ST_NEXT: begin
        if (seg_q) begin
          prev_take = 1'b1;
          state_d   = apc_pkg::ST_IDLE;
        end else if (!pass_q) begin
          prev_take = 1'b1;
          state_d   = last_q ? apc_pkg::ST_EDGE : apc_pkg::ST_IDLE;
        end else begin
          state_d = apc_pkg::ST_CLOSE;
        end
      end
      apc_pkg::ST_CLOSE: begin
        em_vert  = any_q ? fe_q : '0;
        em_valid = any_q;
        em_eop   = 1'b1;
        if (slot_free) begin
          em_go   = 1'b1;
          state_d = apc_pkg::ST_IDLE;
        end
      end
      default: state_d = apc_pkg::ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == apc_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apc_pkg::ST_IDLE;
      axis_q      <= '0;
      plane_q     <= '0;
      start_q     <= '0;
      prev_q      <= '0;
      any_q       <= 1'b0;
      ent_q       <= 1'b0;
      out_valid_q <= 1'b0;
      isel_q      <= 1'b0;
      pass_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite) begin
        if (paddr[2] == apc_pkg::REG_PLANE) plane_q <= pwdata;
        else                                axis_q  <= pwdata[1:0];
      end
      if (state_q == apc_pkg::ST_DECODE && kind_q != apc_pkg::KIND_POINT && first_q) begin
        start_q <= v_q;
        prev_q  <= v_q;
        any_q   <= 1'b0;
        ent_q   <= 1'b0;
      end
      if (latch_edge) pass_q <= 1'b0;
      if (prev_take) begin
        prev_q <= v_q;
        if (!seg_q && !pass_q) pass_q <= 1'b1;
      end
      if (set_ent) ent_q <= 1'b1;
      if (em_go && em_rec && !any_q) any_q <= 1'b1;
      if (state_q == apc_pkg::ST_EDGE) isel_q <= 1'b0;
      if (store_x) isel_q <= !isel_q;
      if (em_go) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      v_q     <= {coord_z_i, coord_y_i, coord_x_i};
      kind_q  <= prim_kind_i;
      first_q <= first_vertex_i;
      last_q  <= last_vertex_i;
    end
    if (latch_edge) begin
      a_q   <= prev_q;
      b_q   <= v_q;
      seg_q <= (kind_q == apc_pkg::KIND_SEGMENT);
    end
    if (prev_take && !seg_q && !pass_q) begin
      a_q <= v_q;
      b_q <= start_q;
    end
    if (state_q == apc_pkg::ST_EDGE) begin
      ka_q <= ka;
      kb_q <= kb;
    end
    if (state_q == apc_pkg::ST_ISECT) x_q[ax] <= pl;
    if (store_x) x_q[ksel] <= res[W-1:0];
    if (em_go && em_rec && !any_q) fe_q <= em_vert;
    if (em_go) begin
      out_v_q   <= em_vert;
      out_vv_q  <= em_valid;
      out_eop_q <= em_eop;
      out_ent_q <= em_ent;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_x_o        = out_v_q[0];
  assign out_y_o        = out_v_q[1];
  assign out_z_o        = out_v_q[2];
  assign vertex_valid_o = out_vv_q;
  assign end_of_prim_o  = out_eop_q;
  assign entered_flag_o = out_ent_q;

  assign prdata = (paddr[2] == apc_pkg::REG_PLANE) ? plane_q : {30'd0, axis_q};
  assign pready = 1'b1;

endmodule
`default_nettype wire

[rtl/apc_checker.sv]
`default_nettype none
module apc_checker #(
  parameter int COORD_BITS = 32
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [COORD_BITS-1:0] out_x_o,
  input wire logic [COORD_BITS-1:0] out_y_o,
  input wire logic [COORD_BITS-1:0] out_z_o,
  input wire logic                  vertex_valid_o,
  input wire logic                  end_of_prim_o,
  input wire logic                  entered_flag_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_x_o) && $stable(out_y_o) &&
      $stable(out_z_o) && $stable(vertex_valid_o) && $stable(end_of_prim_o) &&
      $stable(entered_flag_o))
    else $error("stalled output payload changed");

  a_inv_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !vertex_valid_o |-> end_of_prim_o)
    else $error("invalid marker not at end of primitive");

  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !vertex_valid_o |-> out_x_o == '0 && out_y_o == '0 && out_z_o == '0)
    else $error("invalid marker carries coordinates");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a vertex is in work");

endmodule

bind axis_plane_polygon_clipper_core apc_checker #(.COORD_BITS(COORD_BITS)) u_apc_checker (.*);
`default_nettype wire

[tb/tb_axis_plane_polygon_clipper_core.sv]
`timescale 1ns / 100ps
module tb_axis_plane_polygon_clipper_core;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        vld;
    logic        eop;
    logic        ent;
  } clip_vtx_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic [1:0]  kind;
    logic        first, last;
    int          nexp;
    clip_vtx_t   e0;
  } vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [31:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic [1:0] prim_kind_i = '0;
  logic first_vertex_i = 1'b0, last_vertex_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [31:0] out_x_o, out_y_o, out_z_o;
  logic vertex_valid_o, end_of_prim_o, entered_flag_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #5 clk_i = ~clk_i;

  axis_plane_polygon_clipper_core dut (.*);

  // predictor state
  logic [1:0]         m_axis;
  logic signed [31:0] m_plane;
  logic signed [31:0] m_start[3], m_prev[3], m_firstem[3];
  logic               m_any, m_entered;

  clip_vtx_t clip_q[$];
  int errors = 0;
  int idle_free = 0;
  int stall_cnt = 0;
  bit in_gap_en = 1, out_gap_en = 1;

  function automatic int ax_idx();
    return (m_axis == apc_pkg::AXIS_ALT_Z) ? 2 : int'(m_axis);
  endfunction

  function automatic bit kept(logic signed [31:0] p[3]);
    int a;
    a = ax_idx();
    if (a == 2 || m_plane <= 0) return p[a] >= m_plane;
    return p[a] <= m_plane;
  endfunction

  task automatic isect(input logic signed [31:0] a[3], input logic signed [31:0] b[3],
                       output logic signed [31:0] r[3]);
    int ax;
    logic signed [63:0] da, pa, dk;
    logic [63:0] mda, mpa, mdk, q;
    logic [127:0] prod;
    bit neg;
    ax = ax_idx();
    da = 64'(b[ax]) - 64'(a[ax]);
    pa = 64'(b[ax]) - 64'(m_plane);
    for (int k = 0; k < 3; k++) begin
      if (k == ax) continue;
      dk = 64'(b[k]) - 64'(a[k]);
      mda = da < 0 ? -da : da;
      mpa = pa < 0 ? -pa : pa;
      mdk = dk < 0 ? -dk : dk;
      prod = 128'(mdk) * 128'(mpa);
      q = (mda == 0) ? 64'd0 : 64'(prod / 128'(mda));
      neg = ((dk < 0) != (pa < 0)) != (da < 0);
      r[k] = 32'(64'(b[k]) - (neg ? -q : q));
    end
    r[ax] = m_plane;
  endtask

  task automatic emit(logic signed [31:0] p[3], bit vld, bit rec);
    clip_vtx_t v;
    v.x = vld ? p[0] : '0;
    v.y = vld ? p[1] : '0;
    v.z = vld ? p[2] : '0;
    v.vld = vld;
    v.eop = 1'b0;
    v.ent = m_entered;
    if (rec && vld && !m_any) begin
      m_firstem = p;
      m_any = 1'b1;
    end
    clip_q.push_back(v);
  endtask

  task automatic mark_eop();
    clip_vtx_t v;
    v = clip_q.pop_back();
    v.eop = 1'b1;
    clip_q.push_back(v);
  endtask

  task automatic poly_edge(logic signed [31:0] a[3], logic signed [31:0] b[3]);
    logic signed [31:0] xx[3];
    bit ka, kb;
    ka = kept(a);
    kb = kept(b);
    if (ka) begin
      emit(a, 1, 1);
      if (!kb) begin
        isect(a, b, xx);
        emit(xx, 1, 1);
      end
    end else if (kb) begin
      m_entered = 1'b1;
      isect(a, b, xx);
      emit(xx, 1, 1);
    end
  endtask

  task automatic predict_clip(vec_t t);
    logic signed [31:0] v[3], xx[3];
    clip_vtx_t c;
    bit ka, kb;
    v[0] = t.x;
    v[1] = t.y;
    v[2] = t.z;
    if (t.kind == apc_pkg::KIND_POINT || (t.first && t.last)) begin
      if (t.kind != apc_pkg::KIND_POINT) begin
        m_start = v;
        m_prev = v;
        m_any = 0;
        m_entered = 0;
      end
      emit(v, kept(v), 0);
      c = clip_q.pop_back();
      c.eop = 1;
      c.ent = 0;
      clip_q.push_back(c);
      return;
    end
    if (t.first) begin
      m_start = v;
      m_prev = v;
      m_any = 0;
      m_entered = 0;
      return;
    end
    if (t.kind == apc_pkg::KIND_SEGMENT) begin
      ka = kept(m_prev);
      kb = kept(v);
      if (ka) begin
        emit(m_prev, 1, 0);
        if (kb) emit(v, 1, 0);
        else begin
          isect(m_prev, v, xx);
          emit(xx, 1, 0);
        end
      end else if (kb) begin
        m_entered = 1;
        isect(m_prev, v, xx);
        emit(xx, 1, 0);
        emit(v, 1, 0);
      end else emit(v, 0, 0);
      m_prev = v;
      mark_eop();
      return;
    end
    poly_edge(m_prev, v);
    m_prev = v;
    if (t.last) begin
      poly_edge(v, m_start);
      if (m_any) emit(m_firstem, 1, 0);
      else emit(v, 0, 0);
      mark_eop();
    end
  endtask

  task automatic apb_write(logic reg_sel, logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (reg_sel == apc_pkg::REG_AXIS) m_axis = val[1:0];
    else m_plane = val;
    @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 0;
    wait (clip_q.size() == 0);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic send_vtx(vec_t t);
    int pre;
    pre = clip_q.size();
    if (in_gap_en && idle_free == 0 && $urandom_range(99) < 7) begin
      in_valid_i <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < 7);
    end
    in_valid_i <= 1;
    coord_x_i <= t.x;
    coord_y_i <= t.y;
    coord_z_i <= t.z;
    prim_kind_i <= t.kind;
    first_vertex_i <= t.first;
    last_vertex_i <= t.last;
    predict_clip(t);
    if (t.nexp >= 0) begin
      if (clip_q.size() - pre != t.nexp) begin
        $display("%0t count exp %0d got %0d", $time, t.nexp, clip_q.size() - pre);
        errors++;
      end else if (t.nexp == 1 && clip_q[$] !== t.e0) begin
        $display("%0t table exp %h pred %h", $time, t.e0, clip_q[$]);
        errors++;
      end
    end
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic vec_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [1:0] k,
                              bit f, bit l);
    vec_t t;
    t.x = x; t.y = y; t.z = z; t.kind = k; t.first = f; t.last = l;
    t.nexp = -1;
    t.e0 = '0;
    return t;
  endfunction

  function automatic logic [31:0] rcoord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(40)) - 20) <<< 16;
    endcase
  endfunction

  // output side
  always @(posedge clk_i) begin
    clip_vtx_t got, exp_v;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{out_x_o, out_y_o, out_z_o, vertex_valid_o, end_of_prim_o, entered_flag_o};
        if (clip_q.size() == 0) begin
          $display("%0t unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_v = clip_q.pop_front();
          if (got !== exp_v) begin
            $display("%0t mismatch exp x=%h y=%h z=%h v=%b e=%b f=%b", $time,
                     exp_v.x, exp_v.y, exp_v.z, exp_v.vld, exp_v.eop, exp_v.ent);
            $display("%0t          got x=%h y=%h z=%h v=%b e=%b f=%b", $time,
                     got.x, got.y, got.z, got.vld, got.eop, got.ent);
            errors++;
          end
        end
      end
      out_ready_i <= !(out_gap_en && idle_free == 0 && $urandom_range(99) < 7);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt > 20000) begin
        $display("** axis_plane_polygon_clipper_core: FAILED **");
        $finish;
      end
    end
  end

  vec_t dir_tab[$];

  initial begin
    vec_t t;
    int nv;
    logic [1:0] kk;
    m_axis = 0; m_plane = 0;
    m_start = '{0, 0, 0}; m_prev = '{0, 0, 0}; m_firstem = '{0, 0, 0};
    m_any = 0; m_entered = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // axis x, plane 0: keep x >= 0
    t = mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, apc_pkg::KIND_POINT, 0, 0);
    t.nexp = 1; t.e0 = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 0};
    dir_tab.push_back(t);
    t = mk(32'h8000_0000, 32'h1, 32'h2, apc_pkg::KIND_POINT, 1, 1);
    t.nexp = 1; t.e0 = '{0, 0, 0, 0, 1, 0};
    dir_tab.push_back(t);
    t = mk(32'hFFFF_0000, 5, 6, apc_pkg::KIND_SEGMENT, 1, 1);
    t.nexp = 1; t.e0 = '{0, 0, 0, 0, 1, 0};
    dir_tab.push_back(t);
    t = mk(32'h0001_0000, 5, 6, apc_pkg::KIND_ALT_POLYGON, 1, 1);
    t.nexp = 1; t.e0 = '{32'h0001_0000, 5, 6, 1, 1, 0};
    dir_tab.push_back(t);
    // segment in->out, out->in, in->out, out->out
    dir_tab.push_back(mk(32'h0002_0000, 32'h0004_0000, 0, apc_pkg::KIND_SEGMENT, 1, 0));
    dir_tab.push_back(mk(32'hFFFE_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                         apc_pkg::KIND_SEGMENT, 0, 0));
    dir_tab.push_back(mk(32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         apc_pkg::KIND_SEGMENT, 0, 1));
    dir_tab.push_back(mk(32'hFFFF_0000, 1, 1, apc_pkg::KIND_SEGMENT, 0, 0));
    dir_tab.push_back(mk(32'hFFFF_0000, 2, 2, apc_pkg::KIND_SEGMENT, 0, 0));
    // polygon triangle crossing, then fully clipped, then kind 3 polygon
    dir_tab.push_back(mk(32'h0001_0000, 0, 0, apc_pkg::KIND_POLYGON, 1, 0));
    dir_tab.push_back(mk(32'hFFFF_0000, 32'h0002_0000, 0, apc_pkg::KIND_POLYGON, 0, 0));
    dir_tab.push_back(mk(32'h0001_0000, 32'h0003_0000, 32'h0001_0000,
                         apc_pkg::KIND_POLYGON, 0, 1));
    dir_tab.push_back(mk(32'hFFFF_0000, 0, 0, apc_pkg::KIND_POLYGON, 1, 0));
    dir_tab.push_back(mk(32'hFFFE_0000, 1, 0, apc_pkg::KIND_POLYGON, 0, 0));
    dir_tab.push_back(mk(32'hFFFD_0000, 0, 1, apc_pkg::KIND_POLYGON, 0, 1));
    dir_tab.push_back(mk(32'h7FFF_FFFF, 0, 0, apc_pkg::KIND_ALT_POLYGON, 1, 0));
    dir_tab.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 0, apc_pkg::KIND_ALT_POLYGON, 0, 0));
    dir_tab.push_back(mk(32'h0, 32'h8000_0000, 32'hFFFF_FFFF,
                         apc_pkg::KIND_ALT_POLYGON, 0, 1));
    foreach (dir_tab[i]) send_vtx(dir_tab[i]);

    settle();
    apb_write(apc_pkg::REG_AXIS, apc_pkg::AXIS_Y);
    apb_write(apc_pkg::REG_PLANE, 32'h0001_8000);
    dir_tab.delete();
    dir_tab.push_back(mk(1, 0, 2, apc_pkg::KIND_POLYGON, 1, 0));
    dir_tab.push_back(mk(3, 32'h0004_0000, 5, apc_pkg::KIND_POLYGON, 0, 0));
    dir_tab.push_back(mk(6, 32'h8000_0000, 7, apc_pkg::KIND_POLYGON, 0, 0));
    dir_tab.push_back(mk(8, 32'h7FFF_FFFF, 9, apc_pkg::KIND_POLYGON, 0, 1));
    foreach (dir_tab[i]) send_vtx(dir_tab[i]);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      apb_write(apc_pkg::REG_AXIS, (ph == 5) ? apc_pkg::AXIS_ALT_Z : 2'($urandom_range(2)));
      case (ph)
        0: apb_write(apc_pkg::REG_PLANE, 32'h8000_0000);
        1: apb_write(apc_pkg::REG_PLANE, 32'h7FFF_FFFF);
        2: apb_write(apc_pkg::REG_PLANE, 32'h0);
        default: apb_write(apc_pkg::REG_PLANE, 32'($signed($urandom_range(20)) - 10) <<< 16);
      endcase
      if (ph == 2) idle_free = 1;
      else idle_free = 0;
      for (int n = 0; n < 24; ) begin
        if ($urandom_range(9) == 0) begin
          t = mk(rcoord(), rcoord(), rcoord(), 2'($urandom()), 1'($urandom()),
                 1'($urandom()));
          send_vtx(t);
          n++;
        end else begin
          kk = $urandom_range(9) < 7 ? apc_pkg::KIND_POLYGON : apc_pkg::KIND_SEGMENT;
          if ($urandom_range(7) == 0) kk = apc_pkg::KIND_ALT_POLYGON;
          nv = (kk == apc_pkg::KIND_SEGMENT) ? 2 : $urandom_range(3, 5);
          for (int j = 0; j < nv; j++) begin
            t = mk(rcoord(), rcoord(), rcoord(), kk, j == 0, j == nv - 1);
            send_vtx(t);
            n++;
          end
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("** axis_plane_polygon_clipper_core: PASSED **");
    end else begin
      $display("** axis_plane_polygon_clipper_core: FAILED **");
    end
    $finish;
  end
endmodule
